FILE: rtl/core/teq_pkg.sv
`default_nettype none

package teq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int NFIRE_W     = $clog2(MAX_RESULTS + 1);

  // action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_ADD_ABS = 3'd1;
  localparam logic [2:0] ACT_ADD_DLY = 3'd2;
  localparam logic [2:0] ACT_CANCEL  = 3'd3;
  localparam logic [2:0] ACT_SHUT    = 3'd4;

  // status codes
  localparam logic [3:0] ST_ADDED       = 4'd0;
  localparam logic [3:0] ST_STOPPED     = 4'd1;
  localparam logic [3:0] ST_DUPLICATE   = 4'd2;
  localparam logic [3:0] ST_FULL        = 4'd3;
  localparam logic [3:0] ST_CANCELLED   = 4'd4;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd5;
  localparam logic [3:0] ST_FIRED       = 4'd6;
  localparam logic [3:0] ST_NOTHING_DUE = 4'd7;
  localparam logic [3:0] ST_SHUT_DOWN   = 4'd8;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] tm;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
  } store_req_t;

  // (a + b) mod DEPTH for a, b < DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/teq_store.sv
`default_nettype none

// Entry memory, addressed by queue position relative to the ring head.
module teq_store import teq_pkg::*; (
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] head,
  input  wire store_req_t       req,
  output entry_t                rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  assign rd_addr = wrap_add(head, req.rd_idx);
  assign wr_addr = wrap_add(head, req.wr_idx);

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/core/timed_event_queue.sv
`default_nettype none

// Timed event queue: up to DEPTH pending events (16-bit id, 32-bit expiry
// tick) kept in expiry order, ties in insertion order. Pulse start with an
// action while busy is low; the transaction is taken at that edge. Every
// result appears for exactly one cycle with out_valid high and cannot be
// stalled, so the receiver must take it then; out_last marks the final
// result of a transaction. With N the pending count: shutdown, add while
// stopped, and unused codes 5..7 (no result) finish at acceptance. Add:
// one scan of N reads, then a read and a write per entry moved up to open
// the slot, then one write. Cancel: the same scan, then a read and a write
// per entry moved down. Tick: a read and a check per fired event, then one
// more read or check to finish, at most 16 events per tick. The entry
// memory (one read port, one write port, registered read) sets these
// steps. Events removed from the front only move the ring head.
module timed_event_queue import teq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_action,
  input  wire logic [15:0] in_event_id,
  input  wire logic [31:0] in_event_time,
  output logic             out_valid,
  output logic [3:0]       out_status,
  output logic [15:0]      out_result_id,
  output logic [31:0]      out_result_time,
  output logic             out_last
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN     = 9'b000000010,
    S_INS_RD   = 9'b000000100,
    S_INS_WR   = 9'b000001000,
    S_INS_PUT  = 9'b000010000,
    S_DEL_RD   = 9'b000100000,
    S_DEL_WR   = 9'b001000000,
    S_TICK_RD  = 9'b010000000,
    S_TICK_CHK = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0]        tick_r, tick_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic               stopped_r, stopped_nxt;

  // current transaction
  logic [2:0]         act_r, act_nxt;
  logic [15:0]        id_r, id_nxt;
  logic [31:0]        when_r, when_nxt;

  // scan / shift bookkeeping
  logic [CNT_W-1:0]   k_r, k_nxt;       // next position to read
  logic               pend_r, pend_nxt; // read data in flight
  logic               found_r, found_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;   // insert slot or cancel hit
  logic [CNT_W-1:0]   j_r, j_nxt;       // shift cursor

  // tick firing: one fired event is held back until we know if it is last
  logic [NFIRE_W-1:0] nfire_r, nfire_nxt;
  logic               held_v_r, held_v_nxt;
  entry_t             held_r, held_nxt;

  logic               ov_r;
  logic [3:0]         os_r;
  logic [15:0]        oid_r;
  logic [31:0]        otm_r;
  logic               olast_r;

  logic               emit_v;
  logic [3:0]         emit_st;
  logic [15:0]        emit_id;
  logic [31:0]        emit_tm;
  logic               emit_last;

  store_req_t         req;
  entry_t             ent;

  logic [32:0]        dsum;
  logic [CNT_W-1:0]   j_dn, j_up;

  teq_store u_store (
    .clk     (clk),
    .head    (head_r),
    .req     (req),
    .rd_data (ent)
  );

  assign busy = (state_r != S_IDLE);
  assign dsum = {1'b0, tick_r} + {1'b0, in_event_time};
  assign j_dn = j_r - CNT_W'(1);
  assign j_up = j_r + CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    tick_nxt    = tick_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    stopped_nxt = stopped_r;
    act_nxt     = act_r;
    id_nxt      = id_r;
    when_nxt    = when_r;
    k_nxt       = k_r;
    pend_nxt    = pend_r;
    found_nxt   = found_r;
    pos_nxt     = pos_r;
    j_nxt       = j_r;
    nfire_nxt   = nfire_r;
    held_v_nxt  = held_v_r;
    held_nxt    = held_r;
    req         = '0;
    emit_v      = 1'b0;
    emit_st     = ST_ADDED;
    emit_id     = '0;
    emit_tm     = '0;
    emit_last   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          id_nxt    = in_event_id;
          when_nxt  = in_event_time;
          k_nxt     = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          pos_nxt   = '0;
          unique case (in_action)
            ACT_TICK: begin
              tick_nxt   = tick_r + 32'd1;
              nfire_nxt  = '0;
              held_v_nxt = 1'b0;
              state_nxt  = S_TICK_RD;
            end
            ACT_ADD_ABS, ACT_ADD_DLY: begin
              if (in_action == ACT_ADD_DLY) begin
                // saturate at the top of the tick range
                when_nxt = dsum[32] ? '1 : dsum[31:0];
              end
              if (stopped_r) begin
                emit_v  = 1'b1;
                emit_st = ST_STOPPED;
                emit_id = in_event_id;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_CANCEL: begin
              state_nxt = S_SCAN;
            end
            ACT_SHUT: begin
              count_nxt   = '0;
              stopped_nxt = 1'b1;
              emit_v      = 1'b1;
              emit_st     = ST_SHUT_DOWN;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // pipelined walk: issue position k, check data of position k-1
        if (k_r < count_r) begin
          req.rd_en  = 1'b1;
          req.rd_idx = k_r[IDX_W-1:0];
          k_nxt      = k_r + CNT_W'(1);
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (act_r == ACT_CANCEL) begin
            if (ent.id == id_r && !found_r) begin
              found_nxt = 1'b1;
              pos_nxt   = k_r - CNT_W'(1);
            end
          end else begin
            if (ent.id == id_r) begin
              found_nxt = 1'b1;
            end
            if (ent.tm <= when_r) begin
              pos_nxt = pos_r + CNT_W'(1);
            end
          end
        end
        if (k_r >= count_r && !pend_r) begin
          if (act_r == ACT_CANCEL) begin
            if (!found_r) begin
              emit_v    = 1'b1;
              emit_st   = ST_NOT_FOUND;
              emit_id   = id_r;
              state_nxt = S_IDLE;
            end else if (pos_r == '0) begin
              // front entry: just advance the head
              head_nxt  = wrap_add(head_r, IDX_W'(1));
              count_nxt = count_r - CNT_W'(1);
              emit_v    = 1'b1;
              emit_st   = ST_CANCELLED;
              emit_id   = id_r;
              state_nxt = S_IDLE;
            end else if (pos_r + CNT_W'(1) < count_r) begin
              j_nxt     = pos_r;
              state_nxt = S_DEL_RD;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              emit_v    = 1'b1;
              emit_st   = ST_CANCELLED;
              emit_id   = id_r;
              state_nxt = S_IDLE;
            end
          end else begin
            if (found_r) begin
              emit_v    = 1'b1;
              emit_st   = ST_DUPLICATE;
              emit_id   = id_r;
              state_nxt = S_IDLE;
            end else if (count_r == CNT_W'(DEPTH)) begin
              emit_v    = 1'b1;
              emit_st   = ST_FULL;
              emit_id   = id_r;
              state_nxt = S_IDLE;
            end else begin
              j_nxt     = count_r;
              state_nxt = (count_r > pos_r) ? S_INS_RD : S_INS_PUT;
            end
          end
        end
      end

      S_INS_RD: begin
        req.rd_en  = 1'b1;
        req.rd_idx = j_dn[IDX_W-1:0];
        state_nxt  = S_INS_WR;
      end

      S_INS_WR: begin
        req.wr_en   = 1'b1;
        req.wr_idx  = j_r[IDX_W-1:0];
        req.wr_data = ent;
        j_nxt       = j_dn;
        state_nxt   = (j_dn > pos_r) ? S_INS_RD : S_INS_PUT;
      end

      S_INS_PUT: begin
        req.wr_en      = 1'b1;
        req.wr_idx     = pos_r[IDX_W-1:0];
        req.wr_data.id = id_r;
        req.wr_data.tm = when_r;
        count_nxt      = count_r + CNT_W'(1);
        emit_v         = 1'b1;
        emit_st        = ST_ADDED;
        emit_id        = id_r;
        emit_tm        = when_r;
        state_nxt      = S_IDLE;
      end

      S_DEL_RD: begin
        req.rd_en  = 1'b1;
        req.rd_idx = j_up[IDX_W-1:0];
        state_nxt  = S_DEL_WR;
      end

      S_DEL_WR: begin
        req.wr_en   = 1'b1;
        req.wr_idx  = j_r[IDX_W-1:0];
        req.wr_data = ent;
        j_nxt       = j_up;
        if (j_up + CNT_W'(1) < count_r) begin
          state_nxt = S_DEL_RD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          emit_v    = 1'b1;
          emit_st   = ST_CANCELLED;
          emit_id   = id_r;
          state_nxt = S_IDLE;
        end
      end

      S_TICK_RD: begin
        if (count_r != '0 && nfire_r < NFIRE_W'(MAX_RESULTS)) begin
          req.rd_en  = 1'b1;
          req.rd_idx = '0;
          state_nxt  = S_TICK_CHK;
        end else begin
          emit_v    = 1'b1;
          emit_st   = held_v_r ? ST_FIRED : ST_NOTHING_DUE;
          emit_id   = held_v_r ? held_r.id : 16'd0;
          emit_tm   = held_v_r ? held_r.tm : 32'd0;
          state_nxt = S_IDLE;
        end
      end

      S_TICK_CHK: begin
        if (ent.tm <= tick_r) begin
          head_nxt  = wrap_add(head_r, IDX_W'(1));
          count_nxt = count_r - CNT_W'(1);
          nfire_nxt = nfire_r + NFIRE_W'(1);
          if (held_v_r) begin
            emit_v    = 1'b1;
            emit_st   = ST_FIRED;
            emit_id   = held_r.id;
            emit_tm   = held_r.tm;
            emit_last = 1'b0;
          end
          held_nxt   = ent;
          held_v_nxt = 1'b1;
          state_nxt  = S_TICK_RD;
        end else begin
          emit_v    = 1'b1;
          emit_st   = held_v_r ? ST_FIRED : ST_NOTHING_DUE;
          emit_id   = held_v_r ? held_r.id : 16'd0;
          emit_tm   = held_v_r ? held_r.tm : 32'd0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tick_r    <= '0;
      count_r   <= '0;
      head_r    <= '0;
      stopped_r <= 1'b0;
      pend_r    <= 1'b0;
      held_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tick_r    <= tick_nxt;
      count_r   <= count_nxt;
      head_r    <= head_nxt;
      stopped_r <= stopped_nxt;
      pend_r    <= pend_nxt;
      held_v_r  <= held_v_nxt;
      ov_r      <= emit_v;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    id_r    <= id_nxt;
    when_r  <= when_nxt;
    k_r     <= k_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    j_r     <= j_nxt;
    nfire_r <= nfire_nxt;
    held_r  <= held_nxt;
    os_r    <= emit_st;
    oid_r   <= emit_id;
    otm_r   <= emit_tm;
    olast_r <= emit_last;
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_result_id   = oid_r;
  assign out_result_time = otm_r;
  assign out_last        = olast_r;

endmodule

`default_nettype wire
